// ===== src/oems_pkg.sv =====
// Shared constants and helpers for the odd-even merge float sorter.
`timescale 1ns / 1ps
`default_nettype none
package oems_pkg;
    localparam int MaxElements = 64;
    localparam int IdxW = $clog2(MaxElements);
    localparam int CntW = $clog2(MaxElements + 1);

    // Returns 1 when float a is strictly greater than float b.
    function automatic logic fp_gt(input logic [31:0] a, input logic [31:0] b);
        logic a_nan;
        logic b_nan;
        logic a_zero;
        logic b_zero;
        logic res;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        if (a_nan || b_nan || (a_zero && b_zero))
            res = 1'b0;
        else if (a[31] != b[31])
            res = b[31];
        else if (!a[31])
            res = (a[30:0] > b[30:0]);
        else
            res = (a[30:0] < b[30:0]);
        return res;
    endfunction
endpackage
`default_nettype wire

// ===== src/oems_cmp.sv =====
// Registered float compare unit shared by every compare-exchange.
`timescale 1ns / 1ps
`default_nettype none
module oems_cmp (
    input  wire logic        clk,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic             gt
);
    import oems_pkg::*;
    logic gt_reg;
    always_ff @(posedge clk)
    begin
        gt_reg <= fp_gt(a, b);
    end
    assign gt = gt_reg;
endmodule
`default_nettype wire

// ===== src/odd_even_merge_sort_float.sv =====
// Top level of the odd-even merge float sorter.
`timescale 1ns / 1ps
`default_nettype none
// Loads up to 64 floats one per transfer, sorts them with Batcher's odd-even merge
// network and sends them out in ascending order with tlast on the final one. Sorting
// steps through every (p, k, j, i) position of the iterative network for the padded
// size; each compare-exchange works on the element memory and the one shared comparator
// in turn (read, read, compare, two writes), and a skipped slot only advances the
// position. Each output element is read from memory and then registered onto the output.
// s_tready is low while sorting and emitting.
module odd_even_merge_sort_float (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // in_value
    input  wire logic        s_tlast,   // in_last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // sorted_value
    output logic             m_tlast    // out_last
);
    import oems_pkg::*;

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_SLOT  = 3'd1;
    localparam logic [2:0] ST_RDB   = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_WRA   = 3'd4;
    localparam logic [2:0] ST_WRB   = 3'd5;
    localparam logic [2:0] ST_EMRD  = 3'd6;
    localparam logic [2:0] ST_EMIT  = 3'd7;

    logic [31:0] mem [MaxElements];
    logic [31:0] rdata_reg;
    logic [31:0] va_reg;

    logic [2:0]      state_reg;
    logic [CntW-1:0] cnt_reg;
    logic [CntW-1:0] pad_reg;
    logic [CntW:0]   p_reg;
    logic [CntW:0]   k_reg;
    logic [CntW:0]   j_reg;
    logic [CntW:0]   i_reg;
    logic [CntW-1:0] eidx_reg;
    logic [31:0]     out_data_reg;
    logic            out_last_reg;
    logic            out_valid_reg;

    // Iterative form of the odd-even merge network: index a = i + j, b = a + k.
    logic [CntW+1:0] ia;
    logic [CntW+1:0] ib;
    logic [CntW+1:0] blk_mask;
    logic            slot_ok;
    logic            gt;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    logic [31:0]     wr_data;
    logic [IdxW-1:0] rd_addr;

    assign ia = {1'b0, i_reg} + {1'b0, j_reg};
    assign ib = ia + {1'b0, k_reg};
    // Both positions must fall in the same merge block of size 2p.
    assign blk_mask = {p_reg, 1'b0} - 1'b1;
    assign slot_ok = (ib < {2'b0, cnt_reg})
        && (((ia ^ ib) & ~blk_mask) == '0);

    oems_cmp u_cmp (
        .clk (clk),
        .a   (va_reg),
        .b   (rdata_reg),
        .gt  (gt)
    );

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = cnt_reg[IdxW-1:0];
        wr_data = s_tdata;
        rd_addr = ia[IdxW-1:0];
        case (state_reg)
            ST_LOAD:
            begin
                wr_en = s_tvalid && (cnt_reg < CntW'(MaxElements));
            end
            ST_SLOT: rd_addr = ia[IdxW-1:0];
            ST_RDB:  rd_addr = ib[IdxW-1:0];
            ST_CMP:  rd_addr = ib[IdxW-1:0];
            ST_WRA:
            begin
                wr_en = gt;
                wr_addr = ia[IdxW-1:0];
                wr_data = rdata_reg;
            end
            ST_WRB:
            begin
                wr_en = 1'b0;
            end
            ST_EMRD: rd_addr = eidx_reg[IdxW-1:0];
            default: rd_addr = ia[IdxW-1:0];
        endcase
    end

    logic wrb_en_reg;
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        else if (state_reg == ST_WRB && wrb_en_reg)
            mem[ib[IdxW-1:0]] <= va_reg;
        rdata_reg <= mem[rd_addr];
        if (state_reg == ST_RDB)
            va_reg <= rdata_reg;
        if (state_reg == ST_WRA)
            wrb_en_reg <= gt;
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;
    assign m_tlast = out_last_reg;

    logic [CntW:0] next_p;
    logic [CntW:0] next_k;
    logic [CntW:0] next_j;
    logic [CntW:0] next_i;
    logic          done;

    // Loop order: p doubles, k halves from p, j steps by 2k from k mod p, i over 0..k-1.
    always_comb
    begin
        next_p = p_reg;
        next_k = k_reg;
        next_j = j_reg;
        next_i = i_reg + 1'b1;
        done = 1'b0;
        if (next_i == k_reg)
        begin
            next_i = '0;
            next_j = j_reg + {k_reg[CntW-1:0], 1'b0};
            if (next_j + k_reg >= {1'b0, pad_reg})
            begin
                next_k = k_reg >> 1;
                if (next_k == '0)
                begin
                    next_p = {p_reg[CntW-1:0], 1'b0};
                    next_k = next_p;
                    if (next_p >= {1'b0, pad_reg})
                        done = 1'b1;
                end
                next_j = next_k & (next_p - 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg <= '0;
            pad_reg <= '0;
            p_reg <= '0;
            k_reg <= '0;
            j_reg <= '0;
            i_reg <= '0;
            eidx_reg <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg <= '0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_LOAD:
                begin
                    if (s_tvalid)
                    begin
                        logic [CntW-1:0] n;
                        logic [CntW-1:0] pd;
                        n = (cnt_reg < CntW'(MaxElements)) ? cnt_reg + 1'b1 : cnt_reg;
                        cnt_reg <= n;
                        if (s_tlast)
                        begin
                            pd = CntW'(1);
                            for (int s = 0; s < IdxW; s++)
                                if (pd < n)
                                    pd = {pd[CntW-2:0], 1'b0};
                            pad_reg <= pd;
                            p_reg <= (CntW+1)'(1);
                            k_reg <= (CntW+1)'(1);
                            j_reg <= (CntW+1)'(1) & '0;
                            i_reg <= '0;
                            eidx_reg <= '0;
                            state_reg <= (pd > CntW'(1)) ? ST_SLOT : ST_EMRD;
                        end
                    end
                end
                ST_SLOT:
                begin
                    if (slot_ok)
                        state_reg <= ST_RDB;
                    else
                    begin
                        p_reg <= next_p;
                        k_reg <= next_k;
                        j_reg <= next_j;
                        i_reg <= next_i;
                        state_reg <= done ? ST_EMRD : ST_SLOT;
                    end
                end
                ST_RDB: state_reg <= ST_CMP;
                ST_CMP: state_reg <= ST_WRA;
                ST_WRA: state_reg <= ST_WRB;
                ST_WRB:
                begin
                    p_reg <= next_p;
                    k_reg <= next_k;
                    j_reg <= next_j;
                    i_reg <= next_i;
                    state_reg <= done ? ST_EMRD : ST_SLOT;
                end
                ST_EMRD:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    out_valid_reg <= 1'b1;
                    out_data_reg <= rdata_reg;
                    out_last_reg <= (eidx_reg + 1'b1 == cnt_reg);
                    if (eidx_reg + 1'b1 == cnt_reg)
                    begin
                        cnt_reg <= '0;
                        state_reg <= ST_LOAD;
                    end
                    else
                    begin
                        eidx_reg <= eidx_reg + 1'b1;
                        state_reg <= ST_EMRD;
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
            if (state_reg != ST_EMIT && out_valid_reg && m_tready && state_reg != ST_EMRD)
                out_valid_reg <= 1'b0;
        end
    end

    a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> !s_tready)
        else $error("input ready while busy");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CntW'(MaxElements))
        else $error("count overflow");
    a_hold_output: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output dropped");
endmodule
`default_nettype wire
